// ===== hdl/wheel_period_spike_filter_unit_assert.svh =====
// wheel_period_spike_filter_unit_assert.svh
// Assertion macros for the wheel period spike filter checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef WHEEL_PERIOD_SPIKE_FILTER_UNIT_ASSERT_SVH
`define WHEEL_PERIOD_SPIKE_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define WPSF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wpsf assertion failed");

// Next-cycle implication.
`define WPSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wpsf assertion failed");

`endif

// ===== hdl/wpsf_pkg.sv =====
// wpsf_pkg.sv
// Shared types and constants of the wheel period spike filter.
// No dependencies.
`default_nettype none

package wpsf_pkg;

  // Byte address of the timer wrap register.
  localparam logic [1:0] ADDR_TIMER_WRAP = 2'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;      // capture the accepted transaction
    logic sample;       // run edge detection and period update
    logic pass_clr;     // clear ring walk counter and accumulator
    logic pass_run;     // walk the ring one entry per cycle
    logic filt_mode;    // replace out-of-band entries while walking
    logic div_start;    // start dividing the accumulated sum
    logic div_to_mean;  // quotient goes to the mean, else to the average
    logic bound_load;   // load lower and upper band limits
    logic emit;         // load the result register
  } wpsf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass_done;
    logic div_done;
  } wpsf_sts_t;

endpackage

`default_nettype wire

// ===== hdl/wheel_period_spike_filter_unit.sv =====
// Wheel period spike filter, one sensor channel. A sample transaction
// (req_type_i = 0) carries the pin level and a free-running timer count; on a
// falling edge the block stores the period since the previous falling edge in
// a ring of RING_DEPTH entries, taking one timer wrap (timer_wrap register)
// into account, and reports it. A filter transaction (req_type_i = 1) averages
// the ring, overwrites every entry outside average +/- average/4 with the
// average, averages again and reports that mean. Every transaction returns one
// result. The block works on one transaction at a time. A filter walks the
// ring once per average through the single read port of the ring memory;
// with a depth that is not a power of two, each of the two divisions steps
// through the ring sum 16 bits at a time (STAMP_WIDTH + clog2(RING_DEPTH)
// bits, rounded up). The next transaction is taken while a finished result
// still waits on out_stall_i. The timer wrap register sits at byte address 0
// of the APB port; writes to other addresses are ignored and read back zero.
// Depends on wpsf_pkg, wpsf_ctrl and wpsf_datapath.
`default_nettype none

module wheel_period_spike_filter_unit #(
  parameter int RING_DEPTH  = 8,
  parameter int STAMP_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Input channel
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   req_type_i,
  input  wire logic                   pin_level_i,
  input  wire logic [STAMP_WIDTH-1:0] timer_value_i,
  // Result channel
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        edge_seen_o,
  output logic      [STAMP_WIDTH-1:0] new_period_o,
  output logic      [STAMP_WIDTH-1:0] mean_period_o,
  output logic                        mean_fresh_o,
  // Configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [1:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready
);
  import wpsf_pkg::*;

  logic [STAMP_WIDTH-1:0] timer_wrap_q;
  logic                   cfg_wr;
  wpsf_cmd_t              cmd;
  wpsf_sts_t              sts;

  // Register access: zero wait states, write lands at the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_TIMER_WRAP);
  assign prdata = (paddr == ADDR_TIMER_WRAP) ? 32'(timer_wrap_q) : '0;

  // Reset to the full timer count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_wrap_q <= '1;
    end else if (cfg_wr) begin
      timer_wrap_q <= pwdata[STAMP_WIDTH-1:0];
    end
  end

  // Sequencer: accepts a transaction only when idle, steps the ring walks
  // and divisions, and owns the result valid.
  wpsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Stamps, ring memory, band filter, divider and result register.
  wpsf_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .pin_level_i   (pin_level_i),
    .timer_value_i (timer_value_i),
    .timer_wrap_i  (timer_wrap_q),
    .edge_seen_o   (edge_seen_o),
    .new_period_o  (new_period_o),
    .mean_period_o (mean_period_o),
    .mean_fresh_o  (mean_fresh_o)
  );

endmodule

`default_nettype wire

// ===== hdl/wpsf_ram.sv =====
// wpsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wpsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/wpsf_div.sv =====
// wpsf_div.sv
// Divides the ring sum by the ring depth: a shift for a power-of-two depth,
// otherwise a reciprocal multiplication on one 16-bit digit of the sum per cycle.
`default_nettype none

module wpsf_div #(
  parameter int STAMP_WIDTH = 16,
  parameter int RING_DEPTH  = 8
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          start_i,
  input  wire logic [STAMP_WIDTH+$clog2(RING_DEPTH)-1:0]     dividend_i,
  output logic      [STAMP_WIDTH-1:0]                        quot_o,
  output logic                                               done_o
);

  localparam int SHIFT   = $clog2(RING_DEPTH);
  localparam int SUM_W   = STAMP_WIDTH + SHIFT;
  localparam bit IS_POW2 = (RING_DEPTH & (RING_DEPTH - 1)) == 0;

  if (IS_POW2) begin : g_shift
    logic [STAMP_WIDTH-1:0] quo_q;
    logic                   done_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        quo_q <= dividend_i[SHIFT +: STAMP_WIDTH];
      end
    end

    assign quot_o = quo_q;
    assign done_o = done_q;
  end else begin : g_recip
    // Each step divides remainder:digit (below depth * 2^16) by the depth
    // through a rounded-up reciprocal, exact over that whole range.
    localparam int DIG_W  = 16;
    localparam int N_DIG  = (SUM_W + DIG_W - 1) / DIG_W;
    localparam int PAD_W  = N_DIG * DIG_W;
    localparam int V_W    = DIG_W + SHIFT;
    localparam int K      = V_W + SHIFT;
    localparam int STEP_W = $clog2(N_DIG + 1);
    localparam longint unsigned RECIP_L =
      ((64'd1 << K) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [V_W:0]     RECIP   = (V_W + 1)'(RECIP_L);
    localparam logic [SHIFT-1:0] DIVISOR = SHIFT'(RING_DEPTH);

    logic              busy_q;
    logic              done_q;
    logic [STEP_W-1:0] step_q;
    logic [PAD_W-1:0]  num_q;
    logic [PAD_W-1:0]  quo_q;
    logic [SHIFT-1:0]  rem_q;
    logic [V_W-1:0]    part;
    logic [2*V_W:0]    prod;
    logic [DIG_W-1:0]  digit;
    logic [V_W-1:0]    rest;

    assign part  = {rem_q, num_q[PAD_W-1 -: DIG_W]};
    assign prod  = (2*V_W+1)'(part) * (2*V_W+1)'(RECIP);
    assign digit = prod[K +: DIG_W];
    assign rest  = part - V_W'(digit) * V_W'(DIVISOR);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        step_q <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          step_q <= STEP_W'(N_DIG);
        end else if (busy_q) begin
          step_q <= step_q - 1'b1;
          if (step_q == STEP_W'(1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        num_q <= PAD_W'(dividend_i);
        rem_q <= '0;
      end else if (busy_q) begin
        num_q <= num_q << DIG_W;
        quo_q <= (quo_q << DIG_W) | PAD_W'(digit);
        rem_q <= rest[SHIFT-1:0];
      end
    end

    assign quot_o = quo_q[STAMP_WIDTH-1:0];
    assign done_o = done_q;
  end

endmodule

`default_nettype wire

// ===== hdl/wpsf_datapath.sv =====
// wpsf_datapath.sv
// Stamps, period ring, band filter, mean and result register.
// Depends on wpsf_pkg, wpsf_ram and wpsf_div.
`default_nettype none

module wpsf_datapath #(
  parameter int RING_DEPTH  = 8,
  parameter int STAMP_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire wpsf_pkg::wpsf_cmd_t    cmd_i,
  output wpsf_pkg::wpsf_sts_t         sts_o,
  input  wire logic                   req_type_i,
  input  wire logic                   pin_level_i,
  input  wire logic [STAMP_WIDTH-1:0] timer_value_i,
  input  wire logic [STAMP_WIDTH-1:0] timer_wrap_i,
  output logic                        edge_seen_o,
  output logic      [STAMP_WIDTH-1:0] new_period_o,
  output logic      [STAMP_WIDTH-1:0] mean_period_o,
  output logic                        mean_fresh_o
);
  import wpsf_pkg::*;

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = STAMP_WIDTH + $clog2(RING_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(RING_DEPTH);
  localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(RING_DEPTH - 1);

  // Control state
  logic                   last_level_q;
  logic [STAMP_WIDTH-1:0] stamp_now_q;
  logic [ADDR_W-1:0]      ring_pos_q;
  logic [RING_DEPTH-1:0]  valid_q;
  logic [STAMP_WIDTH-1:0] mean_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   proc_v_q;

  // Payload
  logic                   pin_q;
  logic [STAMP_WIDTH-1:0] tval_q;
  logic                   edge_q;
  logic [STAMP_WIDTH-1:0] period_q;
  logic                   fresh_q;
  logic [SUM_W-1:0]       acc_q;
  logic [STAMP_WIDTH-1:0] avg_q;
  logic [STAMP_WIDTH-1:0] lo_q;
  logic [STAMP_WIDTH:0]   hi_q;
  logic                   rd_vld_q;
  logic [ADDR_W-1:0]      proc_addr_q;
  logic                   res_edge_q;
  logic [STAMP_WIDTH-1:0] res_period_q;
  logic [STAMP_WIDTH-1:0] res_mean_q;
  logic                   res_fresh_q;

  logic                   edge_det;
  logic [STAMP_WIDTH-1:0] wrap_add;
  logic [STAMP_WIDTH-1:0] span;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [STAMP_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [STAMP_WIDTH-1:0] ram_rdata;
  logic [STAMP_WIDTH-1:0] entry;
  logic                   out_band;
  logic [STAMP_WIDTH-1:0] new_val;
  logic [STAMP_WIDTH-1:0] quot;
  logic                   div_done;

  // Falling edge; the previous stamp is the current one before the shift.
  assign edge_det = !pin_q && last_level_q;
  assign wrap_add = (tval_q < stamp_now_q) ? timer_wrap_i : '0;
  assign span     = tval_q - stamp_now_q + wrap_add;

  // Entries never written read as zero.
  assign entry    = rd_vld_q ? ram_rdata : '0;
  assign out_band = ({1'b0, entry} > hi_q) || (entry < lo_q);
  assign new_val  = (cmd_i.filt_mode && out_band) ? avg_q : entry;

  assign ram_re    = cmd_i.pass_run && (cnt_q != CNT_END);
  assign ram_raddr = cnt_q[ADDR_W-1:0];
  assign ram_we    = (cmd_i.sample && edge_det) ||
                     (cmd_i.pass_run && cmd_i.filt_mode && proc_v_q && out_band);
  assign ram_waddr = cmd_i.sample ? ring_pos_q : proc_addr_q;
  assign ram_wdata = cmd_i.sample ? span : avg_q;

  wpsf_ram #(
    .WIDTH (STAMP_WIDTH),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wpsf_div #(
    .STAMP_WIDTH (STAMP_WIDTH),
    .RING_DEPTH  (RING_DEPTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      stamp_now_q  <= '0;
      ring_pos_q   <= '0;
      valid_q      <= '0;
      mean_q       <= '0;
      cnt_q        <= '0;
      proc_v_q     <= 1'b0;
    end else begin
      if (cmd_i.sample) begin
        last_level_q <= pin_q;
        if (edge_det) begin
          stamp_now_q <= tval_q;
          ring_pos_q  <= (ring_pos_q == POS_LAST) ? '0 : ring_pos_q + 1'b1;
        end
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (cmd_i.pass_clr) begin
        cnt_q    <= '0;
        proc_v_q <= 1'b0;
      end else if (cmd_i.pass_run) begin
        proc_v_q <= ram_re;
        if (ram_re) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (div_done && cmd_i.div_to_mean) begin
        mean_q <= quot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pin_q    <= pin_level_i;
      tval_q   <= timer_value_i;
      edge_q   <= 1'b0;
      period_q <= '0;
      fresh_q  <= req_type_i;
    end
    if (cmd_i.sample && edge_det) begin
      edge_q   <= 1'b1;
      period_q <= span;
    end
    if (cmd_i.pass_clr) begin
      acc_q <= '0;
    end else if (cmd_i.pass_run) begin
      rd_vld_q    <= valid_q[ram_raddr];
      proc_addr_q <= ram_raddr;
      if (proc_v_q) begin
        acc_q <= acc_q + SUM_W'(new_val);
      end
    end
    if (div_done && !cmd_i.div_to_mean) begin
      avg_q <= quot;
    end
    if (cmd_i.bound_load) begin
      lo_q <= avg_q - (avg_q >> 2);
      hi_q <= (STAMP_WIDTH + 1)'(avg_q) + (STAMP_WIDTH + 1)'(avg_q >> 2);
    end
    if (cmd_i.emit) begin
      res_edge_q   <= edge_q;
      res_period_q <= period_q;
      res_mean_q   <= mean_q;
      res_fresh_q  <= fresh_q;
    end
  end

  assign sts_o.pass_done = (cnt_q == CNT_END) && !proc_v_q;
  assign sts_o.div_done  = div_done;

  assign edge_seen_o   = res_edge_q;
  assign new_period_o  = res_period_q;
  assign mean_period_o = res_mean_q;
  assign mean_fresh_o  = res_fresh_q;

endmodule

`default_nettype wire

// ===== hdl/wpsf_ctrl.sv =====
// wpsf_ctrl.sv
// Sequencer for sample and filter transactions, input stall, output valid.
// Depends on wpsf_pkg.
`default_nettype none

module wpsf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                req_type_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  input  wire wpsf_pkg::wpsf_sts_t sts_i,
  output wpsf_pkg::wpsf_cmd_t      cmd_o
);
  import wpsf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SAMPLE = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_DIV1   = 3'd3;
  localparam logic [2:0] S_BOUND  = 3'd4;
  localparam logic [2:0] S_FILT   = 3'd5;
  localparam logic [2:0] S_DIV2   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_vld_q;
  logic       out_vld_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (req_type_i) begin
            cmd_o.pass_clr = 1'b1;
            state_d        = S_SUM;
          end else begin
            state_d = S_SAMPLE;
          end
        end
      end
      S_SAMPLE: begin
        cmd_o.sample = 1'b1;
        state_d      = S_EMIT;
      end
      S_SUM: begin
        cmd_o.pass_run = 1'b1;
        if (sts_i.pass_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          state_d = S_BOUND;
        end
      end
      S_BOUND: begin
        cmd_o.bound_load = 1'b1;
        cmd_o.pass_clr   = 1'b1;
        state_d          = S_FILT;
      end
      S_FILT: begin
        cmd_o.pass_run  = 1'b1;
        cmd_o.filt_mode = 1'b1;
        if (sts_i.pass_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd_o.div_to_mean = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // Load once the result register is empty or being drained.
        if (!out_vld_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

// ===== hdl/wpsf_checker.sv =====
// wpsf_checker.sv
// Port-level checks of the wheel period spike filter, bound to the top level.
// Depends on wheel_period_spike_filter_unit_assert.svh.
`default_nettype none
`include "wheel_period_spike_filter_unit_assert.svh"

module wpsf_checker #(
  parameter int STAMP_WIDTH = 16
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_stall_i,
  input wire logic                   edge_seen_i,
  input wire logic [STAMP_WIDTH-1:0] new_period_i,
  input wire logic [STAMP_WIDTH-1:0] mean_period_i,
  input wire logic                   mean_fresh_i
);

  logic [2*STAMP_WIDTH+1:0] res_bus;

  assign res_bus = {edge_seen_i, new_period_i, mean_period_i, mean_fresh_i};

  // Hold a stalled result.
  `WPSF_ASSERT_NEXT(a_out_valid_hold, out_valid_i && out_stall_i, out_valid_i)
  `WPSF_ASSERT_NEXT(a_out_data_hold, out_valid_i && out_stall_i, $stable(res_bus))

  // One transaction at a time: stall right after each accept.
  `WPSF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_i, in_stall_i)

  // A new result only appears after the block was busy with a transaction.
  `WPSF_ASSERT_SAME(a_result_from_work, $rose(out_valid_i), $past(in_stall_i))

endmodule

bind wheel_period_spike_filter_unit wpsf_checker #(
  .STAMP_WIDTH (STAMP_WIDTH)
) u_wpsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_i    (in_stall_o),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .edge_seen_i   (edge_seen_o),
  .new_period_i  (new_period_o),
  .mean_period_i (mean_period_o),
  .mean_fresh_i  (mean_fresh_o)
);

`default_nettype wire
